FILE: design/lrk4_pkg.sv
// Shared types and constants for the Lorenz RK4 step unit.
package lrk4_pkg;

  localparam int unsigned WORD_W = 32;
  localparam int unsigned COEF_W = 31;
  localparam int unsigned DT_W   = 25;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_SIGMA = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RHO   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BETA  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DT    = 2'd3;

  localparam logic FUNC_STEP = 1'b0;
  localparam logic FUNC_LOAD = 1'b1;

  typedef struct packed {
    logic                     func;
    logic signed [WORD_W-1:0] x_init;
    logic signed [WORD_W-1:0] y_init;
    logic signed [WORD_W-1:0] z_init;
  } in_item_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] x_out;
    logic signed [WORD_W-1:0] y_out;
    logic signed [WORD_W-1:0] z_out;
    logic                     saturated;
  } out_item_t;

  // Multiplier operand selects
  typedef enum logic [2:0] {
    MUL_SIGMA_DIFF, // sigma * (hy - v)
    MUL_RHO_HX,     // rho * hx
    MUL_HX_HZ,      // hx * hz
    MUL_HX_HY,      // hx * hy
    MUL_BETA_V,     // beta * v
    MUL_DT_SLOPE    // dt * slope
  } mul_sel_t;

  // Datapath operations issued by the controller, one per cycle
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,        // load point from input
    OP_START,       // hold the point, clear clip flag
    OP_AXIS_INIT,   // v0 = pos[axis], arg = v0, acc = 0
    OP_MUL_A,       // product into pa
    OP_MUL_B,       // product into pb
    OP_SLOPE,       // form slope from pa/pb
    OP_K,           // k = dt * slope, accumulate, build next argument
    OP_DIV,         // first half of the divide by six: register partial quotients
    OP_COMMIT       // finish the divide and update axis; write new point after z
  } dp_op_t;

  typedef struct packed {
    dp_op_t   op;
    mul_sel_t msel;
    logic [1:0] axis;
    logic [1:0] stage;
  } dp_cmd_t;

  typedef struct packed {
    logic div_done;
  } dp_stat_t;

endpackage

FILE: design/lrk4_datapath.sv
// Datapath of the Lorenz RK4 unit: shared multiplier, accumulator, divide by six.
module lrk4_datapath #(
  parameter int FRAC_BITS = 24
) (
  input  logic                       clk,
  input  logic                       rst,
  input  lrk4_pkg::dp_cmd_t          cmd,
  input  lrk4_pkg::in_item_t         in_item,
  input  logic [lrk4_pkg::COEF_W-1:0] sigma,
  input  logic [lrk4_pkg::COEF_W-1:0] rho,
  input  logic [lrk4_pkg::COEF_W-1:0] beta,
  input  logic [lrk4_pkg::DT_W-1:0]   time_step,
  output lrk4_pkg::dp_stat_t         stat,
  output lrk4_pkg::out_item_t        result
);

  localparam int W = lrk4_pkg::WORD_W;
  localparam logic signed [W+3:0] MAX32 = (W+4)'(64'sd2147483647);
  localparam logic signed [W+3:0] MIN32 = -(W+4)'(64'sd2147483648);
  localparam logic signed [W-1:0] MAXW = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] MINW = {1'b1, {(W-1){1'b0}}};
  // Divide by six: the half sum is moved up by 3 * 2^31 and split at bit 18,
  // where 2^18 = 3 * 87381 + 1, so m / 3 = hi * 87381 + (hi + lo) / 3.
  localparam int                  DV_SPLIT  = 18;
  localparam logic signed [W+3:0] DV_OFFSET = (W+4)'(64'sd6442450944);
  localparam logic signed [W+3:0] DV_BIAS   = (W+4)'(64'sd2147483648);
  localparam logic [16:0]         DV_HI_K   = 17'd87381;
  localparam logic [19:0]         DV_RECIP  = 20'd349526;

  // Architectural and working registers
  logic signed [W-1:0] pos_x, pos_y, pos_z;
  logic signed [W-1:0] hold_x, hold_y, hold_z;
  logic signed [W-1:0] nx, ny;
  logic signed [W-1:0] v0, arg, pa, pb, slope;
  logic signed [W+3:0] acc;
  logic                clip;
  // Partial quotients of the divide by six
  logic signed [W+3:0] dv_hi;
  logic [18:0]         dv_t;

  function automatic logic signed [W-1:0] sat_sum(input logic signed [W+3:0] v,
                                                  output logic c);
    c = 1'b0;
    if (v > MAX32) begin
      c = 1'b1;
      return MAXW;
    end
    if (v < MIN32) begin
      c = 1'b1;
      return MINW;
    end
    return v[W-1:0];
  endfunction

  // Multiplier operand selection
  logic signed [W:0]   ma, mb;
  logic signed [W+3:0] diff_w;
  logic signed [W-1:0] diff_s;
  logic                diff_c;
  logic signed [2*W+1:0] prod;
  logic signed [2*W+1:0] prod_sh;
  logic signed [W-1:0] prod_s;
  logic                prod_c;

  always_comb begin
    diff_w = (W+4)'(hold_y) - (W+4)'(arg);
    diff_s = sat_sum(diff_w, diff_c);
    ma = '0;
    mb = '0;
    case (cmd.msel)
      lrk4_pkg::MUL_SIGMA_DIFF: begin
        ma = (W+1)'(diff_s);
        mb = (W+1)'($signed({2'b00, sigma}));
      end
      lrk4_pkg::MUL_RHO_HX: begin
        ma = (W+1)'($signed({2'b00, rho}));
        mb = (W+1)'(hold_x);
      end
      lrk4_pkg::MUL_HX_HZ: begin
        ma = (W+1)'(hold_x);
        mb = (W+1)'(hold_z);
      end
      lrk4_pkg::MUL_HX_HY: begin
        ma = (W+1)'(hold_x);
        mb = (W+1)'(hold_y);
      end
      lrk4_pkg::MUL_BETA_V: begin
        ma = (W+1)'($signed({2'b00, beta}));
        mb = (W+1)'(arg);
      end
      lrk4_pkg::MUL_DT_SLOPE: begin
        ma = (W+1)'($signed({{(W+1-lrk4_pkg::DT_W){1'b0}}, time_step}));
        mb = (W+1)'(slope);
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
    prod = (2*W+2)'(ma) * (2*W+2)'(mb);
    prod_sh = prod >>> FRAC_BITS;
    prod_c = 1'b0;
    if (prod_sh > (2*W+2)'(MAXW)) begin
      prod_s = MAXW;
      prod_c = 1'b1;
    end else if (prod_sh < (2*W+2)'(MINW)) begin
      prod_s = MINW;
      prod_c = 1'b1;
    end else begin
      prod_s = prod_sh[W-1:0];
    end
  end

  // Slope from the two products
  logic signed [W+3:0] slope_w;
  logic signed [W-1:0] slope_s;
  logic                slope_c;
  always_comb begin
    case (cmd.axis)
      2'd1:    slope_w = (W+4)'(pa) - (W+4)'(pb) - (W+4)'(arg);
      2'd2:    slope_w = (W+4)'(pa) - (W+4)'(pb);
      default: slope_w = (W+4)'(pa);
    endcase
    slope_s = sat_sum(slope_w, slope_c);
  end

  // Next stage argument from k
  logic signed [W+3:0] narg_w;
  logic signed [W-1:0] narg_s;
  logic                narg_c;
  logic [2:0]          kweight;
  always_comb begin
    if (cmd.stage == 2'd2)
      narg_w = (W+4)'(v0) + (W+4)'(prod_s);
    else
      narg_w = (W+4)'(v0) + (W+4)'(prod_s >>> 1);
    narg_s = sat_sum(narg_w, narg_c);
    kweight = (cmd.stage == 2'd1 || cmd.stage == 2'd2) ? 3'd2 : 3'd1;
  end

  // Floor divide by six: partial quotients registered in OP_DIV, finished in OP_COMMIT with the final update
  logic [W+3:0]        dv_m;
  logic [W:0]          dv_hi_p;
  logic [18:0]         dv_t_next;
  logic [38:0]         dv_tp;
  logic signed [W+3:0] q_signed;
  logic signed [W+3:0] upd_w;
  logic signed [W-1:0] upd_s;
  logic                upd_c;
  always_comb begin
    dv_m      = (acc >>> 1) + DV_OFFSET;
    dv_hi_p   = (W+1)'(dv_m[W+1:DV_SPLIT]) * (W+1)'(DV_HI_K);
    dv_t_next = 19'(dv_m[W+1:DV_SPLIT]) + 19'(dv_m[DV_SPLIT-1:0]);
    dv_tp     = 39'(dv_t) * 39'(DV_RECIP);
    q_signed  = dv_hi + $signed((W+4)'(dv_tp[38:20]));
    upd_w = (W+4)'(v0) + q_signed;
    upd_s = sat_sum(upd_w, upd_c);
  end

  assign stat.div_done = (cmd.op == lrk4_pkg::OP_DIV);

  always_ff @(posedge clk) begin
    if (rst) begin
      pos_x   <= '0;
      pos_y   <= '0;
      pos_z   <= '0;
      clip    <= 1'b0;
    end else begin
      case (cmd.op)
        lrk4_pkg::OP_LOAD: begin
          pos_x <= in_item.x_init;
          pos_y <= in_item.y_init;
          pos_z <= in_item.z_init;
          clip  <= 1'b0;
        end
        lrk4_pkg::OP_START: begin
          hold_x <= pos_x;
          hold_y <= pos_y;
          hold_z <= pos_z;
          clip   <= 1'b0;
        end
        lrk4_pkg::OP_AXIS_INIT: begin
          case (cmd.axis)
            2'd1:    v0 <= hold_y;
            2'd2:    v0 <= hold_z;
            default: v0 <= hold_x;
          endcase
          case (cmd.axis)
            2'd1:    arg <= hold_y;
            2'd2:    arg <= hold_z;
            default: arg <= hold_x;
          endcase
          acc <= '0;
        end
        lrk4_pkg::OP_MUL_A: begin
          pa <= prod_s;
          clip <= clip | prod_c | ((cmd.msel == lrk4_pkg::MUL_SIGMA_DIFF) & diff_c);
        end
        lrk4_pkg::OP_MUL_B: begin
          pb <= prod_s;
          clip <= clip | prod_c;
        end
        lrk4_pkg::OP_SLOPE: begin
          slope <= slope_s;
          clip  <= clip | slope_c;
        end
        lrk4_pkg::OP_K: begin
          acc <= acc + (W+4)'(prod_s) * $signed({1'b0, kweight});
          if (cmd.stage != 2'd3) begin
            arg  <= narg_s;
            clip <= clip | prod_c | narg_c;
          end else begin
            clip <= clip | prod_c;
          end
        end
        lrk4_pkg::OP_DIV: begin
          // first half: high-part quotient less the offset, and the digit sum
          dv_hi <= $signed((W+4)'(dv_hi_p)) - DV_BIAS;
          dv_t  <= dv_t_next;
        end
        lrk4_pkg::OP_COMMIT: begin
          case (cmd.axis)
            2'd1:    ny <= upd_s;
            2'd2:    ;
            default: nx <= upd_s;
          endcase
          clip <= clip | upd_c;
          if (cmd.axis == 2'd2) begin
            pos_x <= nx;
            pos_y <= ny;
            pos_z <= upd_s;
          end
        end
        default: ;
      endcase
    end
  end

  assign result.x_out     = pos_x;
  assign result.y_out     = pos_y;
  assign result.z_out     = pos_z;
  assign result.saturated = clip;

endmodule

FILE: design/lrk4_ctrl.sv
// Sequencer for the Lorenz RK4 unit: issues one datapath operation per cycle.
module lrk4_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                in_func,
  output logic                out_valid,
  input  logic                out_ready,
  input  lrk4_pkg::dp_stat_t  stat,
  output lrk4_pkg::dp_cmd_t   cmd
);

  typedef enum logic [2:0] {
    S_IDLE, S_START, S_INIT, S_MA, S_MB, S_SLOPE, S_K, S_DIV
  } state_t;

  state_t     state;
  logic [1:0] axis;
  logic [1:0] stage;
  logic       commit;

  logic accept;
  assign in_ready = (state == S_IDLE) && !out_valid;
  assign accept   = in_valid && in_ready;

  // Multiplier choice for the current slope step
  lrk4_pkg::mul_sel_t sel_a, sel_b;
  always_comb begin
    case (axis)
      2'd1: begin
        sel_a = lrk4_pkg::MUL_RHO_HX;
        sel_b = lrk4_pkg::MUL_HX_HZ;
      end
      2'd2: begin
        sel_a = lrk4_pkg::MUL_HX_HY;
        sel_b = lrk4_pkg::MUL_BETA_V;
      end
      default: begin
        sel_a = lrk4_pkg::MUL_SIGMA_DIFF;
        sel_b = lrk4_pkg::MUL_SIGMA_DIFF;
      end
    endcase
  end

  // Decode state into a datapath command
  always_comb begin
    cmd.axis  = axis;
    cmd.stage = stage;
    cmd.msel  = lrk4_pkg::MUL_DT_SLOPE;
    cmd.op    = lrk4_pkg::OP_NONE;
    case (state)
      S_IDLE: begin
        if (accept)
          cmd.op = (in_func == lrk4_pkg::FUNC_LOAD) ? lrk4_pkg::OP_LOAD : lrk4_pkg::OP_NONE;
      end
      S_START: cmd.op = lrk4_pkg::OP_START;
      S_INIT:  cmd.op = lrk4_pkg::OP_AXIS_INIT;
      S_MA: begin
        cmd.op   = lrk4_pkg::OP_MUL_A;
        cmd.msel = sel_a;
      end
      S_MB: begin
        cmd.op   = lrk4_pkg::OP_MUL_B;
        cmd.msel = sel_b;
      end
      S_SLOPE: cmd.op = lrk4_pkg::OP_SLOPE;
      S_K:     cmd.op = lrk4_pkg::OP_K;
      S_DIV:   cmd.op = commit ? lrk4_pkg::OP_COMMIT : lrk4_pkg::OP_DIV;
      default: cmd.op = lrk4_pkg::OP_NONE;
    endcase
  end

  // Hold state and the result flag
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      axis      <= '0;
      stage     <= '0;
      commit    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept) begin
            if (in_func == lrk4_pkg::FUNC_LOAD) out_valid <= 1'b1;
            else                                state     <= S_START;
          end
        end
        S_START: begin
          axis  <= '0;
          state <= S_INIT;
        end
        S_INIT: begin
          stage <= '0;
          state <= S_MA;
        end
        S_MA: state <= (axis == 2'd0) ? S_SLOPE : S_MB;
        S_MB: state <= S_SLOPE;
        S_SLOPE: state <= S_K;
        S_K: begin
          if (stage == 2'd3) begin
            state  <= S_DIV;
            commit <= 1'b0;
          end else begin
            stage <= stage + 2'd1;
            state <= (axis == 2'd0) ? S_MA : ((axis == 2'd1) ? S_MB : S_MA);
          end
        end
        S_DIV: begin
          if (commit) begin
            commit <= 1'b0;
            if (axis == 2'd2) begin
              state     <= S_IDLE;
              out_valid <= 1'b1;
            end else begin
              axis  <= axis + 2'd1;
              state <= S_INIT;
            end
          end else if (stat.div_done) begin
            commit <= 1'b1;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: design/lorenz_rk4_step_unit.sv
// Top level of the Lorenz RK4 step unit.
//  channel | direction | handshake          | payload
//  in      | input     | in_valid/in_ready  | in_item  (func, x/y/z_init)
//  out     | output    | out_valid/out_ready| out_item (x/y/z_out, saturated)
//  cfg     | input     | cfg_we             | cfg_index, cfg_data
// A load answers with the loaded point; a step first holds the point, then runs each
// RK4 stage of x, y and z in turn through the one shared multiplier, and for each
// axis divides by six and updates.
// One transaction is in work at a time; input is held off until the result leaves.
// Synchronous active-high reset clears the point and restores default coefficients.
module lorenz_rk4_step_unit #(
  parameter int FRAC_BITS = 24
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  lrk4_pkg::in_item_t            in_item,
  output logic                          out_valid,
  input  logic                          out_ready,
  output lrk4_pkg::out_item_t           out_item,
  input  logic                          cfg_we,
  input  logic [lrk4_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [lrk4_pkg::COEF_W-1:0]   cfg_data
);

  localparam logic [63:0] ONE = 64'd1 << FRAC_BITS;
  localparam logic [63:0] SIG_D = 64'd10 * ONE;
  localparam logic [63:0] RHO_D = 64'd28 * ONE;
  localparam logic [63:0] BET_D = (64'd8 * ONE + 64'd1) / 64'd3;
  localparam logic [63:0] DT_D  = (ONE + 64'd500) / 64'd1000;
  localparam logic [63:0] M31 = 64'h7FFF_FFFF;
  localparam logic [63:0] M25 = 64'h1FF_FFFF;

  logic [lrk4_pkg::COEF_W-1:0] sigma, rho, beta;
  logic [lrk4_pkg::DT_W-1:0]   time_step;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      sigma     <= lrk4_pkg::COEF_W'(SIG_D > M31 ? M31 : SIG_D);
      rho       <= lrk4_pkg::COEF_W'(RHO_D > M31 ? M31 : RHO_D);
      beta      <= lrk4_pkg::COEF_W'(BET_D > M31 ? M31 : BET_D);
      time_step <= lrk4_pkg::DT_W'(DT_D > M25 ? M25 : DT_D);
    end else if (cfg_we) begin
      case (cfg_index)
        lrk4_pkg::REG_SIGMA: sigma     <= cfg_data;
        lrk4_pkg::REG_RHO:   rho       <= cfg_data;
        lrk4_pkg::REG_BETA:  beta      <= cfg_data;
        lrk4_pkg::REG_DT:    time_step <= cfg_data[lrk4_pkg::DT_W-1:0];
        default: ;
      endcase
    end
  end

  lrk4_pkg::dp_cmd_t  cmd;
  lrk4_pkg::dp_stat_t stat;

  lrk4_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_func   (in_item.func),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  lrk4_datapath #(.FRAC_BITS(FRAC_BITS)) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .in_item   (in_item),
    .sigma     (sigma),
    .rho       (rho),
    .beta      (beta),
    .time_step (time_step),
    .stat      (stat),
    .result    (out_item)
  );

endmodule

FILE: design/lrk4_checker.sv
// Port-level checks for the Lorenz RK4 step unit, bound to the top level.
module lrk4_checker (
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_ready,
  input lrk4_pkg::in_item_t  in_item,
  input logic                out_valid,
  input logic                out_ready,
  input lrk4_pkg::out_item_t out_item
);

  // No new transaction while a result is waiting
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready) else $error("input taken while result pending");

  // A load shows the loaded x and a clear saturation flag on the next cycle
  a_load_echo: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && in_item.func) |=>
      (out_valid && out_item.x_out == $past(in_item.x_init) &&
       out_item.saturated == 1'b0)) else $error("load result wrong");

  // Result holds while stalled
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_item)))
    else $error("result changed under stall");

  // A step never answers in the following cycle
  a_step_latency: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && !in_item.func) |=> !out_valid)
    else $error("step result too early");

endmodule

bind lorenz_rk4_step_unit lrk4_checker u_lrk4_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_item   (in_item),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_item  (out_item)
);

FILE: test/testbench.sv
// Self-checking testbench for the Lorenz RK4 step unit: predicts each point and compares.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAC = 24;
  localparam int STALL_LIMIT = 20000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  lrk4_pkg::in_item_t in_item = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  lrk4_pkg::out_item_t out_item;
  logic cfg_we = 1'b0;
  logic [lrk4_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [lrk4_pkg::COEF_W-1:0] cfg_data = '0;

  lorenz_rk4_step_unit #(.FRAC_BITS(FRAC)) u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
    .out_valid(out_valid), .out_ready(out_ready), .out_item(out_item),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #4 clk = ~clk;

  // Predictor state: coefficients and the current point
  longint coef_sigma, coef_rho, coef_beta, coef_dt;
  longint pt_x, pt_y, pt_z;
  longint hx, hy, hz;
  bit clipped;

  lrk4_pkg::in_item_t pending_items[$];
  lrk4_pkg::out_item_t expected_points[$];
  int errors = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_off_cycles = 0;
  int quiet_cycles = 0;

  function automatic longint sat32(longint v);
    if (v > 64'sd2147483647) begin
      clipped = 1'b1;
      return 64'sd2147483647;
    end
    if (v < -64'sd2147483648) begin
      clipped = 1'b1;
      return -64'sd2147483648;
    end
    return v;
  endfunction

  // Arithmetic shift on longint floors toward minus infinity
  function automatic longint qmul(longint a, longint b);
    return sat32((a * b) >>> FRAC);
  endfunction

  function automatic longint axis_slope(int axis, longint v);
    if (axis == 0) return qmul(sat32(hy - v), coef_sigma);
    if (axis == 1) return sat32(qmul(coef_rho, hx) - qmul(hx, hz) - v);
    return sat32(qmul(hx, hy) - qmul(coef_beta, v));
  endfunction

  function automatic longint rk4_advance(int axis, longint v0);
    longint k1, k2, k3, k4, s, q;
    k1 = qmul(coef_dt, axis_slope(axis, v0));
    k2 = qmul(coef_dt, axis_slope(axis, sat32(v0 + (k1 >>> 1))));
    k3 = qmul(coef_dt, axis_slope(axis, sat32(v0 + (k2 >>> 1))));
    k4 = qmul(coef_dt, axis_slope(axis, sat32(v0 + k3)));
    s = k1 + 2 * k2 + 2 * k3 + k4;
    q = (s >= 0) ? s / 6 : -((-s + 5) / 6);
    return sat32(v0 + q);
  endfunction

  function automatic lrk4_pkg::out_item_t predict_point(lrk4_pkg::in_item_t it);
    lrk4_pkg::out_item_t r;
    longint nx, ny, nz;
    clipped = 1'b0;
    if (it.func == lrk4_pkg::FUNC_LOAD) begin
      pt_x = longint'(it.x_init);
      pt_y = longint'(it.y_init);
      pt_z = longint'(it.z_init);
    end else begin
      hx = pt_x;
      hy = pt_y;
      hz = pt_z;
      nx = rk4_advance(0, pt_x);
      ny = rk4_advance(1, pt_y);
      nz = rk4_advance(2, pt_z);
      pt_x = nx;
      pt_y = ny;
      pt_z = nz;
    end
    r.x_out = pt_x[31:0];
    r.y_out = pt_y[31:0];
    r.z_out = pt_z[31:0];
    r.saturated = clipped;
    return r;
  endfunction

  // Driver: offer the head of the queue, advance on each accepted transaction
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) begin
        expected_points.push_back(predict_point(in_item));
        void'(pending_items.pop_front());
      end
      if (!(in_valid && !in_ready)) begin
        if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          in_item <= pending_items[0];
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver ready, with an optional long hold-off
  always @(posedge clk) begin
    if (hold_off_cycles > 0) begin
      hold_off_cycles <= hold_off_cycles - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Monitor: compare each result with the oldest expectation
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (expected_points.size() == 0) begin
        $display("%0t: unexpected result x=%h y=%h z=%h sat=%b", $time,
                 out_item.x_out, out_item.y_out, out_item.z_out, out_item.saturated);
        errors <= errors + 1;
      end else begin
        if (out_item !== expected_points[0]) begin
          $display("%0t: mismatch expected x=%h y=%h z=%h sat=%b actual x=%h y=%h z=%h sat=%b",
                   $time, expected_points[0].x_out, expected_points[0].y_out,
                   expected_points[0].z_out, expected_points[0].saturated,
                   out_item.x_out, out_item.y_out, out_item.z_out, out_item.saturated);
          errors <= errors + 1;
        end
        void'(expected_points.pop_front());
      end
    end
  end

  // Watchdog on cycles with no transaction
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > STALL_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic write_reg(input logic [lrk4_pkg::CFG_IDX_W-1:0] idx, input longint val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val[lrk4_pkg::COEF_W-1:0];
    case (idx)
      lrk4_pkg::REG_SIGMA: coef_sigma = val & 64'h7FFFFFFF;
      lrk4_pkg::REG_RHO:   coef_rho = val & 64'h7FFFFFFF;
      lrk4_pkg::REG_BETA:  coef_beta = val & 64'h7FFFFFFF;
      default:             coef_dt = val & 64'h1FFFFFF;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic drain();
    while (pending_items.size() > 0 || in_valid || expected_points.size() > 0)
      @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  function automatic logic signed [31:0] rand_word();
    case ($urandom_range(3))
      0: return $signed($urandom());
      1: return $signed(32'($urandom_range(0, 800)) << 20) - 32'sh20000000;
      2: return $signed($urandom_range(0, 60)) <<< 24;
      default: return -($signed($urandom_range(0, 60)) <<< 24);
    endcase
  endfunction

  function automatic lrk4_pkg::in_item_t make_item(logic f, logic signed [31:0] x,
                                                   logic signed [31:0] y,
                                                   logic signed [31:0] z);
    lrk4_pkg::in_item_t it;
    it.func = f;
    it.x_init = x;
    it.y_init = y;
    it.z_init = z;
    return it;
  endfunction

  task automatic queue_random(int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(9) == 0)
        pending_items.push_back(make_item(lrk4_pkg::FUNC_LOAD, rand_word(), rand_word(),
                                          rand_word()));
      else
        pending_items.push_back(make_item(lrk4_pkg::FUNC_STEP, $urandom(), $urandom(),
                                          $urandom()));
    end
  endtask

  initial begin
    coef_sigma = 64'd167772160;
    coef_rho = 64'd469762048;
    coef_beta = 64'd44739243;
    coef_dt = 64'd16777;
    pt_x = 0;
    pt_y = 0;
    pt_z = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed: step from zero, loads at the extremes, steps that saturate
    send_idle_pct = 18;
    recv_idle_pct = 82;
    pending_items.push_back(make_item(lrk4_pkg::FUNC_STEP, 32'sh7FFFFFFF, 0, 0));
    pending_items.push_back(make_item(lrk4_pkg::FUNC_LOAD, 32'sh01000000, 32'sh01000000,
                                      32'sh01000000));
    pending_items.push_back(make_item(lrk4_pkg::FUNC_STEP, 0, 0, 0));
    pending_items.push_back(make_item(lrk4_pkg::FUNC_STEP, 0, 0, 0));
    pending_items.push_back(make_item(lrk4_pkg::FUNC_LOAD, 32'sh7FFFFFFF, 32'sh80000000,
                                      32'sh7FFFFFFF));
    pending_items.push_back(make_item(lrk4_pkg::FUNC_STEP, 0, 0, 0));
    pending_items.push_back(make_item(lrk4_pkg::FUNC_LOAD, 32'sh80000000, 32'sh7FFFFFFF,
                                      32'sh80000000));
    pending_items.push_back(make_item(lrk4_pkg::FUNC_STEP, 0, 0, 0));
    pending_items.push_back(make_item(lrk4_pkg::FUNC_LOAD, -1, -1, -1));
    pending_items.push_back(make_item(lrk4_pkg::FUNC_STEP, -1, -1, -1));
    pending_items.push_back(make_item(lrk4_pkg::FUNC_LOAD, 0, 0, 0));
    pending_items.push_back(make_item(lrk4_pkg::FUNC_STEP, 0, 0, 0));
    drain();

    // Extreme coefficients
    write_reg(lrk4_pkg::REG_SIGMA, 64'h7FFFFFFF);
    write_reg(lrk4_pkg::REG_RHO, 64'h7FFFFFFF);
    write_reg(lrk4_pkg::REG_BETA, 64'h7FFFFFFF);
    write_reg(lrk4_pkg::REG_DT, 64'h1000000);
    pending_items.push_back(make_item(lrk4_pkg::FUNC_LOAD, 32'sh05000000, 32'shFB000000,
                                      32'sh10000000));
    pending_items.push_back(make_item(lrk4_pkg::FUNC_STEP, 0, 0, 0));
    pending_items.push_back(make_item(lrk4_pkg::FUNC_STEP, 0, 0, 0));
    drain();
    write_reg(lrk4_pkg::REG_SIGMA, 0);
    write_reg(lrk4_pkg::REG_RHO, 0);
    write_reg(lrk4_pkg::REG_BETA, 0);
    write_reg(lrk4_pkg::REG_DT, 0);
    pending_items.push_back(make_item(lrk4_pkg::FUNC_LOAD, 32'sh05000000, 32'sh03000000,
                                      32'sh10000000));
    pending_items.push_back(make_item(lrk4_pkg::FUNC_STEP, 0, 0, 0));
    drain();

    // Random, first idle mix; all bits of the data fields toggled by loads
    write_reg(lrk4_pkg::REG_SIGMA, 64'd167772160);
    write_reg(lrk4_pkg::REG_RHO, 64'd469762048);
    write_reg(lrk4_pkg::REG_BETA, 64'd44739243);
    write_reg(lrk4_pkg::REG_DT, 64'd167772);
    pending_items.push_back(make_item(lrk4_pkg::FUNC_LOAD, 32'sh01000000, 32'sh01000000,
                                      32'sh01000000));
    queue_random(180);
    drain();

    // Random, mirrored idle mix with other coefficients; long receiver hold-off
    send_idle_pct = 82;
    recv_idle_pct = 18;
    write_reg(lrk4_pkg::REG_SIGMA, {1'b0, $urandom()} & 64'h7FFFFFFF);
    write_reg(lrk4_pkg::REG_RHO, {1'b0, $urandom()} & 64'h7FFFFFFF);
    write_reg(lrk4_pkg::REG_BETA, {1'b0, $urandom()} & 64'h7FFFFFFF);
    write_reg(lrk4_pkg::REG_DT, $urandom_range(0, 16777216));
    queue_random(180);
    hold_off_cycles = 3000;
    drain();

    // Random, no idling, default-like coefficients with a coarse step
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_reg(lrk4_pkg::REG_SIGMA, 64'd167772160);
    write_reg(lrk4_pkg::REG_RHO, 64'd469762048);
    write_reg(lrk4_pkg::REG_BETA, 64'd44739243);
    write_reg(lrk4_pkg::REG_DT, 64'd335544);
    pending_items.push_back(make_item(lrk4_pkg::FUNC_LOAD, 32'sh01000000, 32'sh02000000,
                                      32'sh03000000));
    queue_random(180);
    drain();

    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

FILE: sim.f
design/lrk4_pkg.sv
design/lrk4_datapath.sv
design/lrk4_ctrl.sv
design/lorenz_rk4_step_unit.sv
design/lrk4_checker.sv
test/testbench.sv
